// File: hdl/ems_pkg.sv
// Shared types, mode codes, register map and reset values of the engine mode supervisor.
package ems_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [2:0] MODE_INIT        = 3'd0;
    localparam logic [2:0] MODE_STOP        = 3'd1;
    localparam logic [2:0] MODE_START       = 3'd2;
    localparam logic [2:0] MODE_RUN_STARTUP = 3'd3;
    localparam logic [2:0] MODE_RUN         = 3'd4;
    localparam logic [2:0] MODE_OVERRUN     = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_STALL_LIMIT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OVERSPEED     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STARTUP_TICKS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PUMP_PRIME    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FUEL_BOOST    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LAMP_OVR      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PUMP_OVR      = 3'd6;

    localparam logic [1:0] OVR_AUTO = 2'd0;
    localparam logic [1:0] OVR_OFF  = 2'd1;
    localparam logic [1:0] OVR_ON   = 2'd2;

    localparam logic [15:0] STALL_LIMIT_RST   = 16'd500;
    localparam logic [15:0] OVERSPEED_RST     = 16'd12000;
    localparam logic [15:0] STARTUP_TICKS_RST = 16'd1000;
    localparam logic [15:0] PUMP_PRIME_RST    = 16'd300;
    localparam logic [15:0] FUEL_BOOST_RST    = 16'd2500;

    localparam logic [15:0] ENRICH_STEP = 16'd10;

    typedef struct packed {
        logic [15:0] stall_limit;
        logic [15:0] overspeed_limit;
        logic [15:0] startup_ticks;
        logic [15:0] pump_prime_ticks;
        logic [15:0] startup_fuel_boost;
        logic [1:0]  lamp_override;
        logic [1:0]  pump_override;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] pump_cnt;
        logic [15:0] startup_cnt;
        logic [15:0] enrich;
        logic        pump;
        logic        lamp;
        logic        valve;
    } t_state;

endpackage

// File: hdl/ems_regs.sv
// Configuration register file with its APB-style access port.
module ems_regs
    import ems_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_STALL_LIMIT:   n_cfg.stall_limit        = pwdata[15:0];
                REG_OVERSPEED:     n_cfg.overspeed_limit    = pwdata[15:0];
                REG_STARTUP_TICKS: n_cfg.startup_ticks      = pwdata[15:0];
                REG_PUMP_PRIME:    n_cfg.pump_prime_ticks   = pwdata[15:0];
                REG_FUEL_BOOST:    n_cfg.startup_fuel_boost = pwdata[15:0];
                REG_LAMP_OVR:      n_cfg.lamp_override      = pwdata[1:0];
                REG_PUMP_OVR:      n_cfg.pump_override      = pwdata[1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_STALL_LIMIT:   prdata = {16'd0, r_cfg.stall_limit};
            REG_OVERSPEED:     prdata = {16'd0, r_cfg.overspeed_limit};
            REG_STARTUP_TICKS: prdata = {16'd0, r_cfg.startup_ticks};
            REG_PUMP_PRIME:    prdata = {16'd0, r_cfg.pump_prime_ticks};
            REG_FUEL_BOOST:    prdata = {16'd0, r_cfg.startup_fuel_boost};
            REG_LAMP_OVR:      prdata = {30'd0, r_cfg.lamp_override};
            REG_PUMP_OVR:      prdata = {30'd0, r_cfg.pump_override};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stall_limit        <= STALL_LIMIT_RST;
            r_cfg.overspeed_limit    <= OVERSPEED_RST;
            r_cfg.startup_ticks      <= STARTUP_TICKS_RST;
            r_cfg.pump_prime_ticks   <= PUMP_PRIME_RST;
            r_cfg.startup_fuel_boost <= FUEL_BOOST_RST;
            r_cfg.lamp_override      <= OVR_AUTO;
            r_cfg.pump_override      <= OVR_AUTO;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: hdl/ems_step.sv
// Next-state logic of the engine mode machine for one control tick.
module ems_step
    import ems_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    input  logic [15:0] i_speed,
    input  logic [15:0] i_load,
    output t_state      o_next
);

    logic [2:0]  by_speed_mode;
    logic        speed_low;
    logic        speed_high;
    logic        lamp_auto;
    logic        lamp_lvl;
    logic        pump_lvl;
    logic [15:0] pump_cnt_nx;
    logic        running;

    assign speed_low  = i_speed < i_cfg.stall_limit;
    assign speed_high = i_speed > i_cfg.overspeed_limit;
    assign running    = (i_state.mode == MODE_RUN) || (i_state.mode == MODE_RUN_STARTUP);

    always_comb begin
        pump_cnt_nx = i_state.pump_cnt;
        pump_lvl    = 1'b0;
        if (running) begin
            pump_cnt_nx = i_cfg.pump_prime_ticks;
            pump_lvl    = 1'b1;
        end else if (i_state.pump_cnt != 16'd0) begin
            pump_cnt_nx = i_state.pump_cnt - 16'd1;
            pump_lvl    = 1'b1;
        end
        if (i_cfg.pump_override != OVR_AUTO) begin
            pump_lvl = i_cfg.pump_override >= OVR_ON;
        end
    end

    assign lamp_auto = (i_state.mode != MODE_RUN) && (i_state.mode != MODE_OVERRUN);
    assign lamp_lvl  = (i_cfg.lamp_override != OVR_AUTO) ?
                       (i_cfg.lamp_override >= OVR_ON) : lamp_auto;

    always_comb begin
        o_next        = i_state;
        by_speed_mode = MODE_STOP;
        unique case (i_state.mode)
            MODE_INIT: begin
                o_next.mode = MODE_STOP;
            end
            MODE_STOP: begin
                o_next.lamp     = lamp_lvl;
                o_next.pump     = pump_lvl;
                o_next.pump_cnt = pump_cnt_nx;
                o_next.mode     = speed_low ? MODE_START :
                                  speed_high ? MODE_OVERRUN : MODE_RUN;
            end
            MODE_START: begin
                o_next.lamp        = lamp_lvl;
                o_next.valve       = 1'b0;
                o_next.pump        = pump_lvl;
                o_next.pump_cnt    = pump_cnt_nx;
                o_next.startup_cnt = i_cfg.startup_ticks;
                o_next.enrich      = i_cfg.startup_fuel_boost;
                o_next.mode        = speed_low ? MODE_START :
                                     speed_high ? MODE_OVERRUN : MODE_RUN_STARTUP;
            end
            MODE_RUN_STARTUP: begin
                o_next.lamp     = lamp_lvl;
                o_next.pump     = pump_lvl;
                o_next.pump_cnt = pump_cnt_nx;
                by_speed_mode   = speed_low ? MODE_START :
                                  speed_high ? MODE_OVERRUN : MODE_RUN_STARTUP;
                o_next.mode     = by_speed_mode;
                if (by_speed_mode == MODE_RUN_STARTUP) begin
                    if (i_state.startup_cnt != 16'd0) begin
                        o_next.startup_cnt = i_state.startup_cnt - 16'd1;
                        if (i_state.enrich > ENRICH_STEP) begin
                            o_next.enrich = i_state.enrich - ENRICH_STEP;
                        end
                    end else begin
                        o_next.mode   = MODE_RUN;
                        o_next.enrich = 16'd0;
                    end
                end
            end
            MODE_RUN: begin
                o_next.lamp     = lamp_lvl;
                o_next.pump     = pump_lvl;
                o_next.pump_cnt = pump_cnt_nx;
                o_next.valve    = (i_load == 16'd0);
                o_next.mode     = speed_low ? MODE_START :
                                  speed_high ? MODE_OVERRUN : MODE_RUN;
            end
            MODE_OVERRUN: begin
                o_next.lamp     = lamp_lvl;
                o_next.pump     = pump_lvl;
                o_next.pump_cnt = pump_cnt_nx;
                o_next.mode     = (i_speed < i_cfg.overspeed_limit) ? MODE_RUN : MODE_OVERRUN;
            end
            default: begin
                o_next.mode = MODE_STOP;
            end
        endcase
    end

endmodule

// File: hdl/engine_mode_supervisor.sv
// Top level of the engine mode supervisor: input register, mode state and result handshake.
//
// The block takes one speed and load word per control tick and can accept a new word in
// every clock cycle while its input is not stalled. A word is captured in an input register;
// the mode machine steps from it in one pass of logic and the new state, which is the
// result word, is registered when the output can take it. While a result waits on a
// stalled output, one more input word is still taken and held. Pump, lamp and valve
// levels hold their values in modes that do not drive them. Configuration writes take
// effect from the next tick that reaches the mode machine.
module engine_mode_supervisor
    import ems_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [15:0]       i_engine_speed,
    input  logic [15:0]       i_engine_load,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_pump_on,
    output logic              o_lamp_on,
    output logic              o_valve_open,
    output logic [15:0]       o_fuel_enrichment,
    output logic [2:0]        o_engine_mode
);

    t_cfg        cfg;
    t_state      r_state;
    t_state      n_state;
    logic        r_in_valid;
    logic [15:0] r_speed;
    logic [15:0] r_load;
    logic        r_out_valid;
    logic        advance;
    logic        in_accept;

    ems_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ems_step u_step (
        .i_cfg   (cfg),
        .i_state (r_state),
        .i_speed (r_speed),
        .i_load  (r_load),
        .o_next  (n_state)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_speed <= i_engine_speed;
            r_load  <= i_engine_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid         <= 1'b0;
            r_state.mode        <= MODE_INIT;
            r_state.pump_cnt    <= PUMP_PRIME_RST;
            r_state.startup_cnt <= 16'd0;
            r_state.enrich      <= 16'd0;
            r_state.pump        <= 1'b1;
            r_state.lamp        <= 1'b0;
            r_state.valve       <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && i_out_stall);
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pump_on         = r_state.pump;
    assign o_lamp_on         = r_state.lamp;
    assign o_valve_open      = r_state.valve;
    assign o_fuel_enrichment = r_state.enrich;
    assign o_engine_mode     = r_state.mode;

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |=> (r_in_valid && r_out_valid))
        else $error("Pending word or result dropped while the output was stalled.");

    a_pump_on_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && cfg.pump_override == OVR_AUTO &&
         (r_state.mode == MODE_RUN || r_state.mode == MODE_RUN_STARTUP)) |=> r_state.pump)
        else $error("Pump off after a tick in a running mode.");

    a_startup_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_state.mode == MODE_START) |=>
        (r_state.startup_cnt == $past(cfg.startup_ticks) &&
         r_state.enrich == $past(cfg.startup_fuel_boost)))
        else $error("Startup countdown or enrichment not loaded in start mode.");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("Input stalled with room in the pipeline.");

endmodule
